// File: sv/dpsb_pkg.sv
// Package for the depth-point to scan-bin block: request/result types, register
// indexes, reset values and the elaboration-time cosine table builder.
// No dependencies.
package dpsb_pkg;

  localparam int unsigned NumBinsDefault = 360;

  localparam logic [14:0] MinHeightReset = 15'd100;
  localparam logic [14:0] MaxHeightReset = 15'd150;
  localparam logic [15:0] EmptyRangeReset = 16'd11000;

  localparam logic [63:0] PiQ62 = 64'hC90FDAA22168C235;
  localparam logic [63:0] OneQ62 = 64'h4000000000000000;
  localparam int unsigned SeriesTerms = 16;

  typedef enum logic [1:0] {
    CFG_MIN_HEIGHT  = 2'd0,
    CFG_MAX_HEIGHT  = 2'd1,
    CFG_EMPTY_RANGE = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] x_mm;
    logic signed [15:0] y_mm;
    logic signed [15:0] z_mm;
    logic [8:0]         bin_number;
  } dpsb_req_t;

  typedef struct packed {
    logic [15:0] range_mm;
    logic        bin_hit;
  } dpsb_res_t;

  // Q62 product, keeping the low 64 bits of (a*b) >> 62
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Restoring long division, used only while building constant tables
  function automatic logic [127:0] udiv_q(input logic [127:0] num, input logic [63:0] den);
    logic [127:0] q;
    logic [64:0]  rem;
    q   = '0;
    rem = '0;
    for (int i = 127; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // cos(pi*m/(2n)) in unsigned Q62 by truncated Taylor series
  function automatic logic [62:0] cos_entry(input int unsigned m, input int unsigned n);
    logic [127:0] qw;
    logic [63:0]  a;
    logic [63:0]  a2;
    logic [63:0]  t;
    logic [63:0]  sum;
    if (m == 0) return OneQ62[62:0];
    if (m >= n) return '0;
    qw  = udiv_q({64'd0, PiQ62} * 128'(m), 64'(2 * n));
    a   = qw[63:0];
    a2  = mul_q62(a, a);
    t   = OneQ62;
    sum = OneQ62;
    for (int unsigned k = 1; k <= SeriesTerms; k++) begin
      qw = udiv_q({64'd0, mul_q62(t, a2)}, 64'((2 * k - 1) * (2 * k)));
      t  = qw[63:0];
      if (k[0]) sum = sum - t;
      else      sum = sum + t;
    end
    if (sum[63]) return '0;
    if (sum > OneQ62) return OneQ62[62:0];
    return sum[62:0];
  endfunction

endpackage

// File: sv/dpsb_cos_rom.sv
// Constant cosine table with two registered read ports.
// Depends on dpsb_pkg (cos_entry).
module dpsb_cos_rom
  import dpsb_pkg::*;
#(
  parameter int unsigned NUM_BINS = NumBinsDefault,
  localparam int unsigned CAW = $clog2(NUM_BINS + 1)
) (
  input  logic           clk_i,
  input  logic [CAW-1:0] addr_a_i,
  input  logic [CAW-1:0] addr_b_i,
  output logic [62:0]    data_a_o,
  output logic [62:0]    data_b_o
);

  logic [62:0] rom_w [NUM_BINS+1];

  // Fill the table at elaboration
  for (genvar g = 0; g <= NUM_BINS; g++) begin : g_ent
    localparam logic [62:0] Ent = cos_entry(g, NUM_BINS);
    assign rom_w[g] = Ent;
  end

  // Register both reads
  always_ff @(posedge clk_i) begin
    data_a_o <= rom_w[addr_a_i];
    data_b_o <= rom_w[addr_b_i];
  end

endmodule

// File: sv/dpsb_bin_mem.sv
// Bin store: one word per bin holding {valid, minimum squared range}.
// Single write port, single registered read port. No dependencies.
module dpsb_bin_mem #(
  parameter int unsigned DEPTH = 360,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/dpsb_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// No dependencies.
module dpsb_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [30:0] val_i,
  output logic        done_o,
  output logic [15:0] root_o
);

  logic [31:0] v_q;
  logic [31:0] r_q;
  logic [31:0] bit_q;
  logic [3:0]  cnt_q;
  logic        run_q;
  logic [31:0] trial_w;

  assign trial_w = r_q + bit_q;
  assign root_o  = r_q[15:0];

  // Step the digit recurrence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        v_q   <= {1'b0, val_i};
        r_q   <= '0;
        bit_q <= 32'h4000_0000;
        cnt_q <= '0;
        run_q <= 1'b1;
      end else if (run_q) begin
        if (v_q >= trial_w) begin
          v_q <= v_q - trial_w;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          run_q  <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/depth_points_to_scan_bins.sv
// Depth points to planar scan bins.
// Requests enter on start/req_i when busy is low. An add request (cmd 0) tests
// a point against the height band and the empty range, finds its bin by a
// binary search over bin boundaries and keeps the smallest squared range in
// the bin. A read request (cmd 1) returns floor(sqrt(minimum)) and bin_hit,
// or the empty range with bin_hit low, and clears the bin.
// Results appear on res_o for one cycle with res_valid_o; the receiver cannot
// stall, so each result must be taken in that cycle.
// An add squares and checks the point, then runs a binary search over the bin
// boundaries whose every step is a cosine table read, a product stage and a
// sign compare, then updates the bin; a point dropped by its checks goes back
// to idle after the check. A read ends at the bin check for an out-of-range
// bin, after the memory read for an empty bin and otherwise when the 16-step
// square root unit is done; its result strobe comes in the first idle cycle.
// One request is worked on at a time; busy stays high until it finishes.
// After reset, a clearing pass writes every one of the NUM_BINS bins empty;
// busy is high during it. Configuration writes (cfg_we_i) are taken at any
// time and must only be issued while the block is idle.
module depth_points_to_scan_bins
  import dpsb_pkg::*;
#(
  parameter int unsigned NUM_BINS = NumBinsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  dpsb_req_t   req_i,
  output logic        res_valid_o,
  output dpsb_res_t   res_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned BW  = $clog2(NUM_BINS);
  localparam int unsigned CAW = $clog2(NUM_BINS + 1);
  localparam logic [BW:0] NumW = (BW + 1)'(NUM_BINS);
  localparam logic [BW-1:0] LastBin = BW'(NUM_BINS - 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SQ, S_CHK, S_SADR, S_SMUL, S_SCMP, S_UWR, S_RRD, S_RCHK, S_RSQ
  } state_e;

  state_e         state_q;
  dpsb_req_t      req_q;
  logic [14:0]    min_h_q;
  logic [14:0]    max_h_q;
  logic [15:0]    empty_q;
  logic [BW-1:0]  clr_cnt_q;
  logic [BW-1:0]  lo_q;
  logic [BW-1:0]  hi_q;
  logic [BW-1:0]  mid_q;
  logic           cneg_q;
  logic [30:0]    xx_q;
  logic [30:0]    zz_q;
  logic [31:0]    lim_q;
  logic           pre_ok_q;
  logic [31:0]    sq_q;
  logic signed [48:0] hz_q;
  logic signed [47:0] lz_q;
  logic signed [48:0] hx_q;
  logic signed [47:0] lx_q;

  // Search address path
  logic [BW:0]    mid_w;
  logic [BW:0]    m2_w;
  logic [CAW-1:0] cos_addr_w;
  logic [CAW-1:0] sin_addr_w;
  logic [62:0]    cos_w;
  logic [62:0]    sin_w;

  assign mid_w = ({1'b0, lo_q} + {1'b0, hi_q} + (BW + 1)'(1)) >> 1;
  assign m2_w  = {mid_w[BW-1:0], 1'b0};
  assign cos_addr_w = (m2_w <= NumW) ? CAW'(m2_w) : CAW'((NumW << 1) - m2_w);
  assign sin_addr_w = (m2_w >= NumW) ? CAW'(m2_w - NumW) : CAW'(NumW - m2_w);

  dpsb_cos_rom #(.NUM_BINS(NUM_BINS)) u_rom (
    .clk_i    (clk_i),
    .addr_a_i (cos_addr_w),
    .addr_b_i (sin_addr_w),
    .data_a_o (cos_w),
    .data_b_o (sin_w)
  );

  // Boundary sign: z*cos - x*sin, exact over split table halves
  logic signed [79:0] hz_w, lz_w, hx_w, lx_w, tz_w, tx_w, diff_w;
  logic               past_w;
  assign hz_w   = hz_q;
  assign lz_w   = lz_q;
  assign hx_w   = hx_q;
  assign lx_w   = lx_q;
  assign tz_w   = (hz_w <<< 31) + lz_w;
  assign tx_w   = (hx_w <<< 31) + lx_w;
  assign diff_w = cneg_q ? (-tz_w - tx_w) : (tz_w - tx_w);
  assign past_w = !diff_w[79];

  // Point checks
  logic signed [16:0] height_w;
  logic               band_w;
  assign height_w = -(17'(req_q.y_mm));
  assign band_w   = (height_w >= $signed({2'b00, min_h_q})) &&
                    (height_w <= $signed({2'b00, max_h_q}));

  logic [31:0] xx_w, zz_w;
  assign xx_w = 32'(req_q.x_mm * req_q.x_mm);
  assign zz_w = 32'(req_q.z_mm * req_q.z_mm);

  // Read request bin
  logic          bin_ok_w;
  logic [BW-1:0] rd_bin_w;
  assign bin_ok_w = 32'(req_q.bin_number) < 32'(NUM_BINS);
  assign rd_bin_w = BW'(req_q.bin_number);

  // Bin memory ports
  logic          mem_we;
  logic [BW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [BW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;
  logic          upd_w;

  assign upd_w = !mem_rdata[31] || (sq_q[30:0] < mem_rdata[30:0]);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = lo_q;
    mem_wdata = {1'b1, sq_q[30:0]};
    mem_raddr = (state_q == S_RRD) ? rd_bin_w : lo_q;
    unique case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
      end
      S_UWR: begin
        mem_we = upd_w;
      end
      S_RCHK: begin
        mem_we    = 1'b1;
        mem_waddr = rd_bin_w;
        mem_wdata = {1'b0, mem_rdata[30:0]};
      end
      default: begin
      end
    endcase
  end

  dpsb_bin_mem #(.DEPTH(NUM_BINS)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Square root of a stored minimum
  logic        sq_start_w;
  logic        sq_done;
  logic [15:0] sq_root;
  assign sq_start_w = (state_q == S_RCHK) && mem_rdata[31];

  dpsb_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start_w),
    .val_i   (mem_rdata[30:0]),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign busy = (state_q != S_IDLE);

  // Sequencer, configuration and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_cnt_q   <= '0;
      min_h_q     <= MinHeightReset;
      max_h_q     <= MaxHeightReset;
      empty_q     <= EmptyRangeReset;
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_HEIGHT:  min_h_q <= cfg_data_i[14:0];
          CFG_MAX_HEIGHT:  max_h_q <= cfg_data_i[14:0];
          CFG_EMPTY_RANGE: empty_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      unique case (state_q)
        S_CLR: begin
          clr_cnt_q <= clr_cnt_q + BW'(1);
          if (clr_cnt_q == LastBin) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            req_q   <= req_i;
            state_q <= (req_i.cmd == CMD_READ) ? S_RRD : S_SQ;
          end
        end
        S_SQ: begin
          xx_q     <= xx_w[30:0];
          zz_q     <= zz_w[30:0];
          lim_q    <= 32'(empty_q) * 32'(empty_q);
          pre_ok_q <= (req_q.x_mm != 16'sd0) && (req_q.y_mm != 16'sd0) &&
                      (req_q.z_mm > 16'sd0) && band_w;
          state_q  <= S_CHK;
        end
        S_CHK: begin
          sq_q <= 32'(xx_q) + 32'(zz_q);
          lo_q <= '0;
          hi_q <= LastBin;
          if (pre_ok_q && ((32'(xx_q) + 32'(zz_q)) < lim_q)) state_q <= S_SADR;
          else state_q <= S_IDLE;
        end
        S_SADR: begin
          if (lo_q >= hi_q) begin
            state_q <= S_UWR;
          end else begin
            mid_q   <= mid_w[BW-1:0];
            cneg_q  <= (m2_w > NumW);
            state_q <= S_SMUL;
          end
        end
        S_SMUL: begin
          hz_q    <= req_q.z_mm * $signed({1'b0, cos_w[62:31]});
          lz_q    <= req_q.z_mm * $signed({1'b0, cos_w[30:0]});
          hx_q    <= req_q.x_mm * $signed({1'b0, sin_w[62:31]});
          lx_q    <= req_q.x_mm * $signed({1'b0, sin_w[30:0]});
          state_q <= S_SCMP;
        end
        S_SCMP: begin
          if (past_w) lo_q <= mid_q;
          else        hi_q <= mid_q - BW'(1);
          state_q <= S_SADR;
        end
        S_UWR: begin
          state_q <= S_IDLE;
        end
        S_RRD: begin
          if (bin_ok_w) begin
            state_q <= S_RCHK;
          end else begin
            res_o       <= '{range_mm: empty_q, bin_hit: 1'b0};
            res_valid_o <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_RCHK: begin
          if (mem_rdata[31]) begin
            state_q <= S_RSQ;
          end else begin
            res_o       <= '{range_mm: empty_q, bin_hit: 1'b0};
            res_valid_o <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_RSQ: begin
          if (sq_done) begin
            res_o       <= '{range_mm: sq_root, bin_hit: 1'b1};
            res_valid_o <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/dpsb_checker.sv
// Port-level checks for depth_points_to_scan_bins, bound to the top level.
// No dependencies.
module dpsb_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic res_valid_o
);

  // An accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("busy not raised after request");

  // Results never come in back-to-back cycles
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o) else $error("result strobe longer than one cycle");

  // A result finishes the request
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy) else $error("result shown while still busy");

endmodule

bind depth_points_to_scan_bins dpsb_checker u_dpsb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o)
);

// File: bench/tb_depth_points_to_scan_bins.sv
// Self-checking bench for depth_points_to_scan_bins: random and directed add/read
// requests, a bit-exact bin predictor in a small scoreboard class.
// Depends on dpsb_pkg and the depth_points_to_scan_bins RTL.
module tb_depth_points_to_scan_bins;
  timeunit 1ns;
  timeprecision 1ps;
  import dpsb_pkg::*;

  localparam int NBins = 360;
  localparam int TailCycles = 60;
  localparam int CycleLimit = 600000;

  // Tracks the scan bins and holds expected read replies in order
  class scan_bin_scoreboard;
    logic [63:0] cos_tab[NBins + 1];
    logic [14:0] band_low;
    logic [14:0] band_high;
    logic [15:0] empty_range;
    logic [30:0] min_range_sq[NBins];
    bit          bin_full[NBins];
    dpsb_res_t   pending_reads[$];
    int          mismatches;
    int          adds_kept;
    int          reads_hit;
    int          reads_seen;

    function new();
      for (int m = 0; m <= NBins; m++) cos_tab[m] = cos_q62(m);
      band_low    = MinHeightReset;
      band_high   = MaxHeightReset;
      empty_range = EmptyRangeReset;
      for (int i = 0; i < NBins; i++) bin_full[i] = 0;
      mismatches = 0;
      adds_kept  = 0;
      reads_hit  = 0;
      reads_seen = 0;
    endfunction

    // cos(pi*m/(2N)) in Q62 from a truncated Taylor series
    function logic [63:0] cos_q62(int m);
      logic [127:0] w;
      logic [63:0]  ang;
      logic [63:0]  ang2;
      logic [63:0]  term;
      logic [63:0]  acc;
      if (m == 0) return OneQ62;
      if (m >= NBins) return 64'd0;
      w    = ({64'd0, PiQ62} * 128'(m)) / 128'(2 * NBins);
      ang  = w[63:0];
      w    = {64'd0, ang} * {64'd0, ang};
      ang2 = w[125:62];
      term = OneQ62;
      acc  = OneQ62;
      for (int k = 1; k <= 16; k++) begin
        w    = {64'd0, term} * {64'd0, ang2};
        term = w[125:62] / 64'((2 * k - 1) * (2 * k));
        if (k % 2 == 1) acc = acc - term;
        else acc = acc + term;
      end
      if (acc[63]) return 64'd0;
      if (acc > OneQ62) return OneQ62;
      return acc;
    endfunction

    // Exact sign of z*cos(j*pi/N) - x*sin(j*pi/N)
    function bit at_or_past(longint x, longint z, int j);
      logic signed [127:0] cv;
      logic signed [127:0] sv;
      logic signed [127:0] acc;
      int d;
      if (2 * j <= NBins) cv = $signed({64'd0, cos_tab[2 * j]});
      else cv = -$signed({64'd0, cos_tab[2 * NBins - 2 * j]});
      d   = NBins - 2 * j;
      sv  = $signed({64'd0, cos_tab[d < 0 ? -d : d]});
      acc = 128'(z) * cv - 128'(x) * sv;
      return acc >= 0;
    endfunction

    function logic [15:0] floor_sqrt(logic [30:0] v);
      logic [31:0] r;
      r = 0;
      for (int b = 15; b >= 0; b--) begin
        if ((r | (32'd1 << b)) * (r | (32'd1 << b)) <= 32'(v)) r = r | (32'd1 << b);
      end
      return r[15:0];
    endfunction

    function void write_reg(cfg_idx_e idx, logic [15:0] val);
      case (idx)
        CFG_MIN_HEIGHT:  band_low = val[14:0];
        CFG_MAX_HEIGHT:  band_high = val[14:0];
        CFG_EMPTY_RANGE: empty_range = val;
        default: begin
        end
      endcase
    endfunction

    // Update the bins for an accepted request, queue a reply for a read
    function void note_request(dpsb_req_t r);
      longint x, y, z, sq, lim;
      int lo, hi, mid;
      dpsb_res_t res;
      if (r.cmd == CMD_ADD) begin
        x = r.x_mm;
        y = r.y_mm;
        z = r.z_mm;
        if (x == 0 || y == 0 || z <= 0) return;
        if (-y > longint'(band_high) || -y < longint'(band_low)) return;
        sq  = x * x + z * z;
        lim = longint'(empty_range) * longint'(empty_range);
        if (sq >= lim) return;
        lo = 0;
        hi = NBins - 1;
        while (lo < hi) begin
          mid = (lo + hi + 1) / 2;
          if (at_or_past(x, z, mid)) lo = mid;
          else hi = mid - 1;
        end
        if (!bin_full[lo] || sq < longint'(min_range_sq[lo])) begin
          min_range_sq[lo] = sq[30:0];
          bin_full[lo]     = 1;
        end
        adds_kept++;
      end else begin
        res.range_mm = empty_range;
        res.bin_hit  = 1'b0;
        if (r.bin_number < NBins) begin
          if (bin_full[r.bin_number]) begin
            res.range_mm = floor_sqrt(min_range_sq[r.bin_number]);
            res.bin_hit  = 1'b1;
          end
          bin_full[r.bin_number] = 0;
        end
        pending_reads.push_back(res);
      end
    endfunction

    function void check_result(dpsb_res_t got);
      dpsb_res_t want;
      reads_seen++;
      if (pending_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result range=%0d hit=%0d",
                                       got.range_mm, got.bin_hit);
        return;
      end
      want = pending_reads.pop_front();
      if (want.bin_hit) reads_hit++;
      if (got.range_mm !== want.range_mm || got.bin_hit !== want.bin_hit) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected range=%0d hit=%0d, got range=%0d hit=%0d",
                   want.range_mm, want.bin_hit, got.range_mm, got.bin_hit);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  dpsb_req_t   req_i = '0;
  logic        res_valid_o;
  dpsb_res_t   res_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  scan_bin_scoreboard bins_sb = new();
  bit allow_gaps = 1;
  int cycle_count = 0;

  depth_points_to_scan_bins DUT (
    .clk_i, .rst_ni, .start, .busy, .req_i, .res_valid_o, .res_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  // Check every read reply in the cycle it is shown
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) bins_sb.check_result(res_o);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Present one request and hold it until the block takes it
  task automatic send_request(dpsb_req_t r);
    if (allow_gaps && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    bins_sb.note_request(r);
  endtask

  task automatic add_point(int x, int y, int z);
    dpsb_req_t r;
    r.cmd        = CMD_ADD;
    r.x_mm       = 16'(x);
    r.y_mm       = 16'(y);
    r.z_mm       = 16'(z);
    r.bin_number = 9'($urandom);
    send_request(r);
  endtask

  task automatic read_bin(int b);
    dpsb_req_t r;
    r.cmd        = CMD_READ;
    r.x_mm       = 16'($urandom);
    r.y_mm       = 16'($urandom);
    r.z_mm       = 16'($urandom);
    r.bin_number = 9'(b);
    send_request(r);
  endtask

  // Drain, let the block settle, then write one register
  task automatic write_reg(cfg_idx_e idx, int val);
    start <= 1'b0;
    @(posedge clk_i);
    while (busy || bins_sb.pending_reads.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= 16'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bins_sb.write_reg(idx, 16'(val));
  endtask

  // Mostly in-band points near the sensor, some raw noise, reads biased to used bins
  task automatic random_traffic(int count);
    int h, reach, b;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 35) begin
        b = $urandom_range(0, 511);
        if ($urandom_range(0, 3) != 0) begin
          for (int t = 0; t < 8; t++) begin
            b = $urandom_range(0, NBins - 1);
            if (bins_sb.bin_full[b]) break;
          end
        end
        read_bin(b);
      end else if ($urandom_range(0, 9) == 0) begin
        add_point($signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)));
      end else begin
        if (bins_sb.band_low <= bins_sb.band_high)
          h = $urandom_range(bins_sb.band_low, bins_sb.band_high);
        else h = $urandom_range(0, 32767);
        reach = (bins_sb.empty_range * 2) / 3 + 1;
        if (reach > 32767) reach = 32767;
        add_point($urandom_range(0, 2 * reach) - reach, -h, $urandom_range(1, reach));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: edges, drops, 45-degree ties, out-of-range reads
    add_point(32767, -120, 1);
    add_point(-32768, -120, 1);
    add_point(1000, -120, 1000);
    add_point(-1000, -120, 1000);
    add_point(1, -100, 7000);
    add_point(-1, -150, 32767);
    add_point(0, -120, 500);
    add_point(500, 0, 500);
    add_point(500, -120, 0);
    add_point(500, -120, -500);
    add_point(500, -99, 500);
    add_point(500, -151, 500);
    add_point(500, 32767, 500);
    add_point(7000, -120, 9000);
    add_point(20, -120, 3000);
    add_point(30, -120, 2000);
    read_bin(180);
    read_bin(180);
    read_bin(90);
    read_bin(270);
    read_bin(359);
    read_bin(0);
    read_bin(360);
    read_bin(511);

    random_traffic(220);
    write_reg(CFG_MIN_HEIGHT, 0);
    write_reg(CFG_MAX_HEIGHT, 32767);
    write_reg(CFG_EMPTY_RANGE, 46341);
    add_point(-32768, -32767, 32767);
    add_point(32767, -32768, 32767);
    random_traffic(250);
    write_reg(CFG_MIN_HEIGHT, 32767);
    write_reg(CFG_MAX_HEIGHT, 0);
    random_traffic(60);
    write_reg(CFG_MIN_HEIGHT, 500);
    write_reg(CFG_MAX_HEIGHT, 500);
    write_reg(CFG_EMPTY_RANGE, 0);
    random_traffic(60);
    write_reg(CFG_MIN_HEIGHT, $urandom_range(0, 2000));
    write_reg(CFG_MAX_HEIGHT, $urandom_range(2000, 32767));
    write_reg(CFG_EMPTY_RANGE, $urandom_range(1, 3000));
    random_traffic(250);
    allow_gaps = 0;
    random_traffic(150);

    // Drain the last replies and let the block go quiet
    start <= 1'b0;
    while (bins_sb.pending_reads.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    $display("covered %0d replies (%0d from filled bins) and %0d kept points",
             bins_sb.reads_seen, bins_sb.reads_hit, bins_sb.adds_kept);
    $display("over five register settings, mismatches: %0d", bins_sb.mismatches);
    if (bins_sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// File: depth_points_to_scan_bins.f
sv/dpsb_pkg.sv
sv/dpsb_cos_rom.sv
sv/dpsb_bin_mem.sv
sv/dpsb_isqrt.sv
sv/depth_points_to_scan_bins.sv
sv/dpsb_checker.sv
bench/tb_depth_points_to_scan_bins.sv
